// ===== src/sgnms_pkg.sv =====
`default_nettype none
package sgnms_pkg;

  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 4096;
  localparam int ColBits   = $clog2(MaxWidth);
  localparam int RowBits   = $clog2(MaxHeight) + 1;
  localparam int WidthBits = ColBits + 1;
  localparam int HeightBits = $clog2(MaxHeight) + 1;
  localparam int MagBits   = 11;
  localparam int RadBits   = 2 * MagBits;
  localparam int RemBits   = MagBits + 3;
  localparam int RootSteps = MagBits;
  localparam int StepBits  = $clog2(RootSteps + 1);
  localparam int GradBits  = 12;

  localparam logic [1:0] RegImageWidth  = 2'd0;
  localparam logic [1:0] RegImageHeight = 2'd1;

  localparam logic [WidthBits-1:0]  WidthReset  = WidthBits'(640);
  localparam logic [HeightBits-1:0] HeightReset = HeightBits'(480);

  localparam logic [1:0] SecHorizontal = 2'd0;
  localparam logic [1:0] SecRising     = 2'd1;
  localparam logic [1:0] SecVertical   = 2'd2;
  localparam logic [1:0] SecFalling    = 2'd3;

  typedef struct packed {
    logic               load_in;
    logic               pix_keep;
    logic               shift_pix;
    logic               grad;
    logic               square;
    logic               root_step;
    logic               shift_mag;
    logic               load_out;
    logic               q_int;
    logic               o_valid;
    logic               o_int;
    logic               o_last;
    logic [ColBits-1:0] pix_addr;
    logic [ColBits-1:0] mag_addr;
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== src/sgnms_dp.sv =====
`default_nettype none
module sgnms_dp (
  input  wire                    clk,
  input  wire                    rst,
  input  sgnms_pkg::dp_cmd_t     cmd,
  output sgnms_pkg::dp_status_t  status,
  input  wire  [7:0]             pixel,
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic                   valid_res,
  output logic [7:0]             edge_value,
  output logic [1:0]             direction,
  output logic                   frame_last
);

  localparam int MB = sgnms_pkg::MagBits;
  localparam int GB = sgnms_pkg::GradBits;
  localparam int RB = sgnms_pkg::RadBits;
  localparam int EB = sgnms_pkg::RemBits;

  logic [7:0]    pix_line_upper  [sgnms_pkg::MaxWidth];
  logic [7:0]    pix_line_middle [sgnms_pkg::MaxWidth];
  logic [MB-1:0] mag_line_upper  [sgnms_pkg::MaxWidth];
  logic [MB-1:0] mag_line_middle [sgnms_pkg::MaxWidth];
  logic [1:0]    sec_line_middle [sgnms_pkg::MaxWidth];

  logic [7:0]    pix_in;
  logic [7:0]    pix_up_rd, pix_mid_rd;
  logic [MB-1:0] mag_up_rd, mag_mid_rd;
  logic [1:0]    sec_rd;
  logic [7:0]    pw [3][3];
  logic [MB-1:0] mw [3][3];
  logic signed [GB-1:0] gx, gy;
  logic [RB-1:0] rad;
  logic [EB-1:0] rem;
  logic [MB-1:0] root;
  logic [1:0]    sec;
  logic [1:0]    sec_held;
  logic [1:0]    csec;

  // Pixel line stores: read in the accept cycle, written back in the cycle after it.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pix_up_rd  <= pix_line_upper[cmd.pix_addr];
      pix_mid_rd <= pix_line_middle[cmd.pix_addr];
      pix_in     <= cmd.pix_keep ? pixel : 8'd0;
    end
    if (cmd.shift_pix) begin
      pix_line_upper[cmd.pix_addr]  <= pix_mid_rd;
      pix_line_middle[cmd.pix_addr] <= pix_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_pix) begin
      for (int k = 0; k < 3; k++) begin
        pw[k][0] <= pw[k][1];
        pw[k][1] <= pw[k][2];
      end
      pw[0][2] <= pix_up_rd;
      pw[1][2] <= pix_mid_rd;
      pw[2][2] <= pix_in;
    end
  end

  // Magnitude and sector line stores.
  always_ff @(posedge clk) begin
    if (cmd.shift_pix) begin
      mag_up_rd  <= mag_line_upper[cmd.mag_addr];
      mag_mid_rd <= mag_line_middle[cmd.mag_addr];
      sec_rd     <= sec_line_middle[cmd.mag_addr];
    end
    if (cmd.shift_mag) begin
      mag_line_upper[cmd.mag_addr]  <= mag_mid_rd;
      mag_line_middle[cmd.mag_addr] <= cmd.q_int ? root : '0;
      sec_line_middle[cmd.mag_addr] <= cmd.q_int ? sec : sgnms_pkg::SecHorizontal;
    end
  end

  // Sobel sums.
  logic [GB-1:0] right_sum, left_sum, top_sum, bottom_sum;
  always_comb begin
    right_sum  = GB'(pw[0][2]) + GB'({pw[1][2], 1'b0}) + GB'(pw[2][2]);
    left_sum   = GB'(pw[0][0]) + GB'({pw[1][0], 1'b0}) + GB'(pw[2][0]);
    top_sum    = GB'(pw[0][0]) + GB'({pw[0][1], 1'b0}) + GB'(pw[0][2]);
    bottom_sum = GB'(pw[2][0]) + GB'({pw[2][1], 1'b0}) + GB'(pw[2][2]);
  end

  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      gx <= $signed(right_sum - left_sum);
      gy <= $signed(top_sum - bottom_sum);
    end
  end

  // Squares and sector quantisation against tan 22.5 degrees.
  logic [MB-1:0]   abs_x, abs_y;
  logic [MB:0]     abs_sum;
  logic [2*MB-1:0] sq_x, sq_y;
  logic [2*MB+1:0] sq_sum;
  logic            flip;
  logic [1:0]      sec_next;
  always_comb begin
    abs_x   = gx[GB-1] ? MB'(-gx) : MB'(gx);
    abs_y   = gy[GB-1] ? MB'(-gy) : MB'(gy);
    abs_sum = {1'b0, abs_x} + {1'b0, abs_y};
    sq_x    = abs_x * abs_x;
    sq_y    = abs_y * abs_y;
    sq_sum  = abs_sum * abs_sum;
    flip    = gy[GB-1] || (gy == '0 && gx[GB-1]);
    if (gx == '0 && gy == '0) begin
      sec_next = sgnms_pkg::SecHorizontal;
    end else if (sq_sum < {1'b0, sq_x, 1'b0}) begin
      sec_next = sgnms_pkg::SecHorizontal;
    end else if (sq_sum < {1'b0, sq_y, 1'b0}) begin
      sec_next = sgnms_pkg::SecVertical;
    end else if ((gx != '0 && !gx[GB-1]) ^ flip) begin
      sec_next = sgnms_pkg::SecRising;
    end else begin
      sec_next = sgnms_pkg::SecFalling;
    end
  end

  // Square root, one result bit per step.
  logic [EB-1:0] rem_sh, trial;
  always_comb begin
    rem_sh = {rem[EB-3:0], rad[RB-1:RB-2]};
    trial  = {1'b0, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      rad  <= RB'({1'b0, sq_x} + {1'b0, sq_y});
      sec  <= sec_next;
      rem  <= '0;
      root <= '0;
    end else if (cmd.root_step) begin
      rad <= {rad[RB-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[MB-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[MB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_mag) begin
      for (int k = 0; k < 3; k++) begin
        mw[k][0] <= mw[k][1];
        mw[k][1] <= mw[k][2];
      end
      mw[0][2] <= mag_up_rd;
      mw[1][2] <= mag_mid_rd;
      mw[2][2] <= cmd.q_int ? root : '0;
      csec     <= sec_held;
      sec_held <= sec_rd;
    end
  end

  // Suppression along the held sector.
  logic [MB-1:0] ctr, n0, n1;
  logic [7:0]    edge_next;
  always_comb begin
    ctr = mw[1][1];
    case (csec)
      sgnms_pkg::SecHorizontal: begin n0 = mw[1][0]; n1 = mw[1][2]; end
      sgnms_pkg::SecRising:     begin n0 = mw[0][2]; n1 = mw[2][0]; end
      sgnms_pkg::SecVertical:   begin n0 = mw[0][1]; n1 = mw[2][1]; end
      default:                  begin n0 = mw[0][0]; n1 = mw[2][2]; end
    endcase
    if (!cmd.o_int || ctr < n0 || ctr < n1) begin
      edge_next = 8'd0;
    end else if (ctr > MB'(255)) begin
      edge_next = 8'd255;
    end else begin
      edge_next = ctr[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      valid_res  <= cmd.o_valid;
      edge_value <= edge_next;
      direction  <= cmd.o_int ? csec : sgnms_pkg::SecHorizontal;
      frame_last <= cmd.o_last;
    end
  end

  assign status.out_full = out_valid;

endmodule
`default_nettype wire

// ===== src/sgnms_ctrl.sv =====
`default_nettype none
module sgnms_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire                    pad,
  input  wire                    out_stall,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire  [1:0]             cfg_index,
  input  wire  [12:0]            cfg_data,
  input  sgnms_pkg::dp_status_t  status,
  output sgnms_pkg::dp_cmd_t     cmd
);

  localparam int CB = sgnms_pkg::ColBits;
  localparam int RB = sgnms_pkg::RowBits;
  localparam int WB = sgnms_pkg::WidthBits;
  localparam int HB = sgnms_pkg::HeightBits;
  localparam int PB = RB + 1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PIXRD  = 7'b0000010,
    S_GRAD   = 7'b0000100,
    S_SQUARE = 7'b0001000,
    S_ROOT   = 7'b0010000,
    S_MAGWR  = 7'b0100000,
    S_RESULT = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [CB-1:0] col;
  logic [RB-1:0] row;
  logic [WB-1:0] width;
  logic [HB-1:0] height;
  logic [sgnms_pkg::StepBits-1:0] steps;

  logic signed [PB-1:0] qr, orow, hmax;
  logic [WB-1:0] qc, oc, wmax;
  logic q_int, o_valid, o_int, o_last;
  logic accept, drain_ok, cfg_wr;
  logic [WB-1:0] w_clamped;
  logic [HB-1:0] h_clamped;

  // Positions of the gradient centre and of the suppression centre.
  always_comb begin
    hmax = $signed(PB'(height)) - PB'(2);
    wmax = width - WB'(2);
    if (col != '0) begin
      qr = $signed(PB'(row)) - PB'(1);
      qc = WB'(col) - WB'(1);
    end else begin
      qr = $signed(PB'(row)) - PB'(2);
      qc = width - WB'(1);
    end
    if (qc != '0) begin
      orow = qr - PB'(1);
      oc   = qc - WB'(1);
    end else begin
      orow = qr - PB'(2);
      oc   = width - WB'(1);
    end
    q_int   = qr >= PB'(1) && qr <= hmax && qc >= WB'(1) && qc <= wmax;
    o_valid = orow >= PB'(0);
    o_int   = orow >= PB'(1) && orow <= hmax && oc >= WB'(1) && oc <= wmax;
    o_last  = orow == $signed(PB'(height)) - PB'(1) && oc == width - WB'(1);
  end

  always_comb begin
    w_clamped = cfg_data[WB-1:0];
    if (cfg_data[WB-1:0] < WB'(3)) begin
      w_clamped = WB'(3);
    end else if (cfg_data[WB-1:0] > WB'(sgnms_pkg::MaxWidth)) begin
      w_clamped = WB'(sgnms_pkg::MaxWidth);
    end
    h_clamped = cfg_data[HB-1:0];
    if (cfg_data[HB-1:0] < HB'(3)) begin
      h_clamped = HB'(3);
    end else if (cfg_data[HB-1:0] > HB'(sgnms_pkg::MaxHeight)) begin
      h_clamped = HB'(sgnms_pkg::MaxHeight);
    end
  end

  // A configuration write takes precedence over an input transaction.
  assign in_stall  = state != S_IDLE || cfg_valid;
  assign cfg_ready = state == S_IDLE;
  assign accept    = in_valid && !in_stall;
  assign cfg_wr    = cfg_valid && cfg_ready;
  // The result register is free, or its transaction completes this cycle.
  assign drain_ok  = !status.out_full || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_PIXRD;
      S_PIXRD:  state_next = S_GRAD;
      S_GRAD:   state_next = S_SQUARE;
      S_SQUARE: state_next = S_ROOT;
      S_ROOT:   if (steps == sgnms_pkg::StepBits'(sgnms_pkg::RootSteps - 1)) state_next = S_MAGWR;
      S_MAGWR:  state_next = S_RESULT;
      S_RESULT: if (drain_ok) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      col    <= '0;
      row    <= '0;
      steps  <= '0;
      width  <= sgnms_pkg::WidthReset;
      height <= sgnms_pkg::HeightReset;
    end else begin
      state <= state_next;
      if (state == S_ROOT) begin
        steps <= steps + 1'b1;
      end else begin
        steps <= '0;
      end
      if (cfg_wr && (cfg_index == sgnms_pkg::RegImageWidth ||
                     cfg_index == sgnms_pkg::RegImageHeight)) begin
        if (cfg_index == sgnms_pkg::RegImageWidth) begin
          width <= w_clamped;
        end else begin
          height <= h_clamped;
        end
        col <= '0;
        row <= '0;
      end else if (state == S_RESULT && drain_ok) begin
        if (o_last) begin
          col <= '0;
          row <= '0;
        end else if (WB'(col) + WB'(1) >= width) begin
          col <= '0;
          row <= row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
    end
  end

  always_comb begin
    cmd.load_in   = accept;
    cmd.pix_keep  = PB'(row) < PB'(height) && !pad;
    cmd.shift_pix = state == S_PIXRD;
    cmd.grad      = state == S_GRAD;
    cmd.square    = state == S_SQUARE;
    cmd.root_step = state == S_ROOT;
    cmd.shift_mag = state == S_MAGWR;
    cmd.load_out  = state == S_RESULT && drain_ok;
    cmd.q_int     = q_int;
    cmd.o_valid   = o_valid;
    cmd.o_int     = o_int;
    cmd.o_last    = o_last;
    cmd.pix_addr  = col;
    cmd.mag_addr  = qc[CB-1:0];
  end

endmodule
`default_nettype wire

// ===== src/sobel_gradient_nonmax_suppress.sv =====
`default_nettype none
// Channel  Handshake               Payload
// in       in_valid / in_stall    pixel, pad
// out      out_valid / out_stall  valid_res, edge_value, direction, frame_last
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each item passes through accept, line read, gradient, squares, 11 square root
// steps, magnitude window update and result; the input stalls meanwhile.
// Reset sets width 640, height 480 and the frame position to zero; the line stores
// are not cleared.
// A result waits in the output register while the next item is already taken; an
// item's last cycle holds until that register is free.
module sobel_gradient_nonmax_suppress (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  pixel,
  input  wire         pad,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        valid_res,
  output logic [7:0]  edge_value,
  output logic [1:0]  direction,
  output logic        frame_last,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [12:0] cfg_data
);

  sgnms_pkg::dp_cmd_t    cmd;
  sgnms_pkg::dp_status_t status;

  sgnms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pad       (pad),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .cmd       (cmd)
  );

  sgnms_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .pixel      (pixel),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .valid_res  (valid_res),
    .edge_value (edge_value),
    .direction  (direction),
    .frame_last (frame_last)
  );

endmodule
`default_nettype wire

// ===== src/sgnms_checker.sv =====
`default_nettype none
module sgnms_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire        valid_res,
  input wire [7:0]  edge_value,
  input wire [1:0]  direction,
  input wire        frame_last
);

  // One item in flight: the input side stalls after each transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(edge_value) && $stable(frame_last))
    else $error("stalled result changed");

  a_last_is_real: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> valid_res)
    else $error("frame end on a fill result");

  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> edge_value == 8'd0 && direction == 2'd0)
    else $error("fill result carries data");

  a_edge_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> edge_value == 8'd0 && direction == 2'd0)
    else $error("last frame pixel is a border pixel and must be zero");

endmodule

bind sobel_gradient_nonmax_suppress sgnms_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .valid_res  (valid_res),
  .edge_value (edge_value),
  .direction  (direction),
  .frame_last (frame_last)
);
`default_nettype wire
